>>> rtl/kspc_pkg.sv
// shared types, codes and reset constants for the keypad servo pwm controller
package kspc_pkg;

    // parameter defaults
    localparam int MAX_ANGLE_DEF   = 180;
    localparam int COUNT_WIDTH_DEF = 16;

    // configuration register indexes
    localparam logic [1:0] REG_PERIOD    = 2'd0;
    localparam logic [1:0] REG_MIN_PULSE = 2'd1;
    localparam logic [1:0] REG_PER_DEG   = 2'd2;
    localparam logic [1:0] REG_NUDGE     = 2'd3;

    // configuration reset values
    localparam logic [15:0] PERIOD_RST    = 16'd60000;
    localparam logic [15:0] MIN_PULSE_RST = 16'd1800;
    localparam logic [7:0]  PER_DEG_RST   = 8'd30;
    localparam logic [7:0]  NUDGE_RST     = 8'd10;

    // state reset values
    localparam logic [15:0] WIDTH_RST = 16'd4500;
    localparam logic [7:0]  ANGLE_HOME = 8'd90;

    // beat kinds
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_KEY  = 1'b1;

    // key codes
    localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
    localparam logic [3:0] KEY_STAR       = 4'd10;
    localparam logic [3:0] KEY_HASH       = 4'd11;

    typedef struct packed {
        logic [15:0] period_clocks;
        logic [15:0] min_pulse_clocks;
        logic [7:0]  clocks_per_degree;
        logic [7:0]  nudge_degrees;
    } cfg_t;

    typedef struct packed {
        logic [15:0] pulse_width_clocks;
        logic [7:0]  angle_degrees;
        logic        pwm_level;
    } result_t;

endpackage

>>> rtl/kspc_ctrl.sv
// keypad decode, angle state and pulse width calculation
module kspc_ctrl #(
    parameter int MAX_ANGLE = kspc_pkg::MAX_ANGLE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  kspc_pkg::cfg_t     cfg,
    input  logic               key_accept,
    input  logic [3:0]         key_code,
    output logic [7:0]         angle_next,
    output logic [15:0]        pulse_next
);
    import kspc_pkg::*;

    localparam logic [7:0] MAX_A     = 8'(MAX_ANGLE);
    localparam logic [7:0] ANGLE_RST = (MAX_ANGLE < 90) ? MAX_A : ANGLE_HOME;

    logic [7:0] angle_reg;
    logic       digit_phase_reg;
    logic       digit_phase_next;
    logic [9:0] first_digit_reg;
    logic [9:0] first_digit_next;

    logic [8:0]  hash_sum;
    logic [9:0]  digit_sum;
    logic [7:0]  below;
    logic [15:0] product;
    logic [16:0] width_sum;

    always_comb
    begin
        angle_next       = angle_reg;
        digit_phase_next = digit_phase_reg;
        first_digit_next = first_digit_reg;
        hash_sum  = {1'b0, angle_reg} + {1'b0, cfg.nudge_degrees};
        digit_sum = first_digit_reg + {3'd0, key_code, 3'd0} + {5'd0, key_code, 1'b0};
        if (key_accept)
        begin
            if (key_code == KEY_STAR)
            begin
                angle_next = (angle_reg > cfg.nudge_degrees) ?
                             angle_reg - cfg.nudge_degrees : 8'd0;
                digit_phase_next = 1'b0;
                first_digit_next = '0;
            end
            else if (key_code == KEY_HASH)
            begin
                angle_next = (hash_sum > {1'b0, MAX_A}) ? MAX_A : hash_sum[7:0];
                digit_phase_next = 1'b0;
                first_digit_next = '0;
            end
            else if (key_code <= KEY_LAST_DIGIT)
            begin
                if (!digit_phase_reg)
                begin
                    first_digit_next = 10'd100 * {6'd0, key_code};
                    digit_phase_next = 1'b1;
                end
                else
                begin
                    angle_next = (digit_sum > {2'b00, MAX_A}) ? MAX_A : digit_sum[7:0];
                    first_digit_next = '0;
                    digit_phase_next = 1'b0;
                end
            end
        end
    end

    // pulse width from the updated angle, saturated to 16 bits
    always_comb
    begin
        below     = MAX_A - angle_next;
        product   = {8'd0, cfg.clocks_per_degree} * {8'd0, below};
        width_sum = {1'b0, cfg.min_pulse_clocks} + {1'b0, product};
        pulse_next = width_sum[16] ? 16'hFFFF : width_sum[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg       <= ANGLE_RST;
            digit_phase_reg <= 1'b0;
            first_digit_reg <= '0;
        end
        else
        begin
            angle_reg       <= angle_next;
            digit_phase_reg <= digit_phase_next;
            first_digit_reg <= first_digit_next;
        end
    end

    a_angle_bound: assert property (@(posedge clk) disable iff (!rst_n)
        angle_reg <= MAX_A)
        else $error("angle above limit");

    a_phase_clears_digit: assert property (@(posedge clk) disable iff (!rst_n)
        !digit_phase_reg |-> first_digit_reg == '0)
        else $error("stale first digit");

    a_no_key_holds_angle: assert property (@(posedge clk) disable iff (!rst_n)
        !key_accept |=> angle_reg == $past(angle_reg))
        else $error("angle moved without a key");

endmodule

>>> rtl/kspc_pwm.sv
// frame counter, width latch and pwm drive level
module kspc_pwm #(
    parameter int COUNT_WIDTH = kspc_pkg::COUNT_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tick,
    input  logic [15:0] period_clocks,
    input  logic [15:0] pulse_width,
    output logic        pwm_level
);
    import kspc_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    logic [COUNT_WIDTH-1:0] tick_count_reg;
    logic [COUNT_WIDTH-1:0] tick_count_next;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [15:0]            latched_reg;
    logic [15:0]            latched_next;
    logic                   drive_reg;
    logic                   drive_next;

    always_comb
    begin
        latched_next    = latched_reg;
        drive_next      = drive_reg;
        tick_count_next = tick_count_reg;
        count_inc       = tick_count_reg + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
        if (tick)
        begin
            // width is taken at the first tick of each frame
            if (tick_count_reg == '0)
                latched_next = pulse_width;
            drive_next = CMP_W'(tick_count_reg) < CMP_W'(latched_next);
            tick_count_next = (CMP_W'(count_inc) >= CMP_W'(period_clocks)) ? '0 : count_inc;
        end
    end

    assign pwm_level = drive_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            latched_reg    <= WIDTH_RST;
            drive_reg      <= 1'b1;
        end
        else
        begin
            tick_count_reg <= tick_count_next;
            latched_reg    <= latched_next;
            drive_reg      <= drive_next;
        end
    end

    a_latch_only_at_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        (tick && tick_count_reg != '0) |=> latched_reg == $past(latched_reg))
        else $error("width changed mid frame");

    a_level_held_on_key: assert property (@(posedge clk) disable iff (!rst_n)
        !tick |=> drive_reg == $past(drive_reg) && tick_count_reg == $past(tick_count_reg))
        else $error("pwm moved without a tick");

    a_short_period_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (tick && period_clocks <= 16'd1) |=> tick_count_reg == '0)
        else $error("counter did not wrap");

endmodule

>>> rtl/kspc_obuf.sv
// result register with a skid stage toward the master side
module kspc_obuf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  kspc_pkg::result_t push_data,
    output logic              push_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output kspc_pkg::result_t out_data
);
    import kspc_pkg::*;

    result_t main_reg;
    result_t skid_reg;
    logic    main_valid_reg;
    logic    skid_valid_reg;

    assign push_ready = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_data   = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                main_valid_reg <= push;
        end
        else if (push)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
                main_reg <= skid_reg;
            else if (push)
                main_reg <= push_data;
        end
        else if (push)
            skid_reg <= push_data;
    end

    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid full with output empty");

    a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (push && main_valid_reg && !out_ready) |=> skid_valid_reg)
        else $error("beat dropped under stall");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_ready) |=> main_valid_reg && !skid_valid_reg)
        else $error("skid did not drain");

endmodule

>>> rtl/keypad_servo_pwm_controller_core.sv
// top level of the keypad servo pwm controller
//
// input beats arrive on s_tvalid/s_tready: s_tuser is the kind (0 timer tick,
// 1 key press), s_tdata[3:0] the key code (0..9 digits, 10 star, 11 hash).
// every beat gives exactly one result beat on m_tvalid/m_tready carrying the
// pwm level after that beat, the commanded angle and its pulse width.
// the result is registered in the result register that drives m_tvalid, or
// first in the skid stage under a stall; one beat can be accepted every cycle
// while s_tready is high; the decode and multiply are combinational.
// a result register plus a skid stage separate the two sides: while the
// receiver stalls the block still takes one more beat, then holds s_tready low
// until the skid stage drains. s_tready never depends on m_tready in the same
// cycle.
// reset sets the angle to 90 degrees (or the limit if lower), clears the frame
// counter and two-digit entry, drives the pin high, latches a width of 4500
// ticks, loads register defaults. the user must write registers through
// cfg_wen/cfg_index/cfg_data while no beat is in flight; not enforced here.
module keypad_servo_pwm_controller_core #(
    parameter int MAX_ANGLE   = kspc_pkg::MAX_ANGLE_DEF,
    parameter int COUNT_WIDTH = kspc_pkg::COUNT_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // key_code[3:0], zero pad [7:4]
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // pwm_level[0], angle_degrees[8:1],
                                   // pulse_width_clocks[24:9], zero pad [31:25]
);
    import kspc_pkg::*;

    cfg_t        cfg_reg;
    logic        accept;
    logic        key_accept;
    logic        tick;
    logic [7:0]  angle_next;
    logic [15:0] pulse_next;
    logic        level;
    result_t     result;
    result_t     out_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period_clocks     <= PERIOD_RST;
            cfg_reg.min_pulse_clocks  <= MIN_PULSE_RST;
            cfg_reg.clocks_per_degree <= PER_DEG_RST;
            cfg_reg.nudge_degrees     <= NUDGE_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_PERIOD:    cfg_reg.period_clocks     <= cfg_data;
                REG_MIN_PULSE: cfg_reg.min_pulse_clocks  <= cfg_data;
                REG_PER_DEG:   cfg_reg.clocks_per_degree <= cfg_data[7:0];
                REG_NUDGE:     cfg_reg.nudge_degrees     <= cfg_data[7:0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign accept     = s_tvalid && s_tready;
    assign key_accept = accept && (s_tuser == ACT_KEY);
    assign tick       = accept && (s_tuser == ACT_TICK);

    kspc_ctrl #(
        .MAX_ANGLE (MAX_ANGLE)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .key_accept (key_accept),
        .key_code   (s_tdata[3:0]),
        .angle_next (angle_next),
        .pulse_next (pulse_next)
    );

    kspc_pwm #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_pwm (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick          (tick),
        .period_clocks (cfg_reg.period_clocks),
        .pulse_width   (pulse_next),
        .pwm_level     (level)
    );

    always_comb
    begin
        result.pwm_level          = level;
        result.angle_degrees      = angle_next;
        result.pulse_width_clocks = pulse_next;
    end

    kspc_obuf u_obuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (result),
        .push_ready (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_result)
    );

    assign m_tdata = {7'd0, out_result};

endmodule
